// ===== hdl/sbgu_pkg.sv =====
// Shared types and constants of the spectrum bar gravity update unit.
// Used by the configuration registers, the column store and the top level.
`default_nettype none

package sbgu_pkg;

    localparam int ADDR_W = 3;

    localparam logic REG_GRAVITY  = 1'b0;
    localparam logic REG_MAX_RISE = 1'b1;

    localparam logic signed [24:0] GRAVITY_RESET  = -25'sd3932160;
    localparam logic        [30:0] MAX_RISE_RESET = 31'd327680000;

    typedef struct packed {
        logic signed [24:0] gravity;
        logic        [30:0] max_rise;
    } cfg_t;

    typedef struct packed {
        logic        [23:0] height;
        logic signed [31:0] velocity;
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/sbgu_cfg_regs.sv =====
// APB-style register file holding the gravity and rise clamp settings.
// Depends on sbgu_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module sbgu_cfg_regs
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sbgu_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output sbgu_pkg::cfg_t                    cfg
);

    logic signed [24:0] gravity_reg;
    logic        [30:0] max_rise_reg;
    logic               wr_en;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= sbgu_pkg::GRAVITY_RESET;
            max_rise_reg <= sbgu_pkg::MAX_RISE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sbgu_pkg::REG_GRAVITY:  gravity_reg  <= $signed(pwdata[24:0]);
                sbgu_pkg::REG_MAX_RISE: max_rise_reg <= pwdata[30:0];
                default:                gravity_reg  <= gravity_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sbgu_pkg::REG_GRAVITY:  prdata = {{7{gravity_reg[24]}}, gravity_reg};
            sbgu_pkg::REG_MAX_RISE: prdata = {1'b0, max_rise_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.gravity  = gravity_reg;
    assign cfg.max_rise = max_rise_reg;

endmodule

`default_nettype wire

// ===== hdl/sbgu_col_store.sv =====
// Per-column height and velocity state, cleared to zero at reset.
// Depends on sbgu_pkg for state_t.
`default_nettype none

module sbgu_col_store
#(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_idx,
    output sbgu_pkg::state_t      rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire sbgu_pkg::state_t wr_data
);

    sbgu_pkg::state_t store_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            store_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = store_reg[rd_idx];

endmodule

`default_nettype wire

// ===== hdl/spectrum_bar_gravity_update_unit.sv =====
// An accepted item moves from stage one through stages two to four into the output register.
// Throughput: one item per cycle unless the output stalls; an item whose column matches an
// in-range item in stages two to four waits in stage one until that item writes back.
// The height and velocity of a column are read in stage one and written back from stage four.
// Reset clears all column state to zero and loads the default gravity and rise clamp.
// Depends on sbgu_pkg, sbgu_cfg_regs and sbgu_col_store.
`default_nettype none

module spectrum_bar_gravity_update_unit
#(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sbgu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [4:0]                  column,
    input  wire logic signed [31:0]          rise_rate,
    input  wire logic [15:0]                 frame_time,
    output logic                             bar_valid,
    input  wire logic                        bar_stall,
    output logic [4:0]                       bar_column,
    output logic [4:0]                       bar_height
);

    localparam int DEPTH = (COLUMNS < 32) ? COLUMNS : 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [23:0] HMAX = 24'(ROWS * 65536);

    sbgu_pkg::cfg_t   cfg;
    sbgu_pkg::state_t rd_state;
    sbgu_pkg::state_t wr_state;

    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic v1_next, v2_next, v3_next, v4_next, vo_next;
    logic r1, r2, r3, r4, r5;
    logic hazard;
    logic wr_en;

    logic [4:0]         col1_reg, col2_reg, col3_reg, col4_reg, col_out_reg;
    logic               inr1_reg, inr2_reg, inr3_reg, inr4_reg;
    logic [30:0]        rise1_reg, rise2_reg;
    logic [15:0]        ft1_reg, ft2_reg, ft3_reg;
    logic signed [25:0] gstep1_reg;
    logic [23:0]        h2_reg, h3_reg, h4_reg;
    logic signed [31:0] vel2_reg, vel3_reg, vel4_reg;
    logic signed [32:0] sum3_reg;
    logic signed [33:0] step4_reg;
    logic [4:0]         height_out_reg;

    logic               inr1_next;
    logic [30:0]        rise1_next;
    logic signed [41:0] gprod;
    logic signed [25:0] gstep1_next;
    logic signed [32:0] vsum;
    logic signed [31:0] vel2_next;
    logic signed [32:0] sum3_next;
    logic signed [49:0] prod;
    logic signed [33:0] step4_next;
    logic signed [34:0] hsum;
    logic [23:0]        h_new;
    logic [4:0]         height_out_next;

    sbgu_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbgu_col_store #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_col_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (col1_reg[IDX_W-1:0]),
        .rd_data (rd_state),
        .wr_en   (wr_en),
        .wr_idx  (col4_reg[IDX_W-1:0]),
        .wr_data (wr_state)
    );

    always_comb
    begin
        hazard = v1_reg && inr1_reg &&
                 ((v2_reg && inr2_reg && (col2_reg == col1_reg)) ||
                  (v3_reg && inr3_reg && (col3_reg == col1_reg)) ||
                  (v4_reg && inr4_reg && (col4_reg == col1_reg)));
        r5 = !vo_reg || !bar_stall;
        r4 = !v4_reg || r5;
        r3 = !v3_reg || r4;
        r2 = !v2_reg || r3;
        r1 = !v1_reg || (r2 && !hazard);
        v1_next = r1 ? item_valid : v1_reg;
        v2_next = r2 ? (v1_reg && !hazard) : v2_reg;
        v3_next = r3 ? v2_reg : v3_reg;
        v4_next = r4 ? v3_reg : v4_reg;
        vo_next = r5 ? v4_reg : vo_reg;
    end

    assign item_stall = !r1;
    assign wr_en      = v4_reg && inr4_reg && r5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            vo_reg <= vo_next;
        end
    end

    always_comb
    begin
        inr1_next = ({4'b0, column} < 9'(COLUMNS));
        if (rise_rate[31])
        begin
            rise1_next = 31'd0;
        end
        else if (rise_rate[30:0] > cfg.max_rise)
        begin
            rise1_next = cfg.max_rise;
        end
        else
        begin
            rise1_next = rise_rate[30:0];
        end
        gprod = $signed({{17{cfg.gravity[24]}}, cfg.gravity}) *
                $signed({26'b0, frame_time});
        gstep1_next = gprod[41:16];
    end

    always_comb
    begin
        vsum = $signed({rd_state.velocity[31], rd_state.velocity}) +
               $signed({{7{gstep1_reg[25]}}, gstep1_reg});
        if (rd_state.height == 24'd0)
        begin
            vel2_next = 32'sd0;
        end
        else if (vsum[32] != vsum[31])
        begin
            vel2_next = vsum[32] ? $signed(32'h8000_0000) : $signed(32'h7FFF_FFFF);
        end
        else
        begin
            vel2_next = vsum[31:0];
        end
    end

    always_comb
    begin
        sum3_next  = $signed({vel2_reg[31], vel2_reg}) + $signed({2'b0, rise2_reg});
        prod       = $signed({{17{sum3_reg[32]}}, sum3_reg}) * $signed({34'b0, ft3_reg});
        step4_next = prod[49:16];
    end

    always_comb
    begin
        hsum = $signed({11'b0, h4_reg}) + $signed({step4_reg[33], step4_reg});
        if (hsum[34])
        begin
            h_new = 24'd0;
        end
        else if (hsum[33:0] > {10'b0, HMAX})
        begin
            h_new = HMAX;
        end
        else
        begin
            h_new = hsum[23:0];
        end
        wr_state.height   = h_new;
        wr_state.velocity = vel4_reg;
        height_out_next   = inr4_reg ? h_new[20:16] : 5'd0;
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            col1_reg   <= column;
            inr1_reg   <= inr1_next;
            rise1_reg  <= rise1_next;
            ft1_reg    <= frame_time;
            gstep1_reg <= gstep1_next;
        end
        if (r2)
        begin
            col2_reg  <= col1_reg;
            inr2_reg  <= inr1_reg;
            rise2_reg <= rise1_reg;
            ft2_reg   <= ft1_reg;
            h2_reg    <= rd_state.height;
            vel2_reg  <= vel2_next;
        end
        if (r3)
        begin
            col3_reg <= col2_reg;
            inr3_reg <= inr2_reg;
            ft3_reg  <= ft2_reg;
            h3_reg   <= h2_reg;
            vel3_reg <= vel2_reg;
            sum3_reg <= sum3_next;
        end
        if (r4)
        begin
            col4_reg  <= col3_reg;
            inr4_reg  <= inr3_reg;
            h4_reg    <= h3_reg;
            vel4_reg  <= vel3_reg;
            step4_reg <= step4_next;
        end
        if (r5)
        begin
            col_out_reg    <= col4_reg;
            height_out_reg <= height_out_next;
        end
    end

    assign bar_valid  = vo_reg;
    assign bar_column = col_out_reg;
    assign bar_height = height_out_reg;

`ifndef ASSERT_OFF
    a_no_same_column_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(v2_reg && v3_reg && inr2_reg && inr3_reg && (col2_reg == col3_reg)))
        else $error("Two in-flight items update the same column.");

    a_hazard_holds_stage_one: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && hazard) |=> (v1_reg && $stable(col1_reg)))
        else $error("An item under a column hazard left stage one.");

    a_height_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid |-> ({3'b0, bar_height} <= 8'(ROWS)))
        else $error("Bar height exceeds the row count.");

    a_unknown_column_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (bar_valid && ({4'b0, bar_column} >= 9'(COLUMNS))) |-> (bar_height == 5'd0))
        else $error("A column beyond the display produced a nonzero height.");
`endif

endmodule

`default_nettype wire

// ===== tb/spectrum_bar_gravity_update_unit_tb.sv =====
// Self-checking testbench for the spectrum bar gravity update unit: random and directed
// column updates, random idling on both channels, APB register writes between phases.
// Depends on sbgu_pkg and the spectrum_bar_gravity_update_unit RTL.
`timescale 1ns / 1ps

module spectrum_bar_gravity_update_unit_tb;

    localparam int COLUMNS     = 32;
    localparam int ROWS        = 16;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [sbgu_pkg::ADDR_W-1:0] GRAVITY_ADDR  = {sbgu_pkg::REG_GRAVITY, 2'b00};
    localparam logic [sbgu_pkg::ADDR_W-1:0] MAX_RISE_ADDR = {sbgu_pkg::REG_MAX_RISE, 2'b00};

    typedef struct packed {
        logic [4:0]  column;
        logic [31:0] rise_rate;
        logic [15:0] frame_time;
    } bar_update_t;

    typedef struct packed {
        logic [4:0] column;
        logic [4:0] height;
    } bar_result_t;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        psel       = 1'b0;
    logic                        penable    = 1'b0;
    logic                        pwrite     = 1'b0;
    logic [sbgu_pkg::ADDR_W-1:0] paddr      = '0;
    logic [31:0]                 pwdata     = '0;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        item_valid = 1'b0;
    logic                        item_stall;
    logic [4:0]                  column     = '0;
    logic [31:0]                 rise_rate  = '0;
    logic [15:0]                 frame_time = '0;
    logic                        bar_valid;
    logic                        bar_stall  = 1'b0;
    logic [4:0]                  bar_column;
    logic [4:0]                  bar_height;

    bar_update_t column_updates[$];
    bar_result_t pending_bars[$];
    bar_update_t next_update;
    bar_result_t want_bar;

    logic signed [24:0] cur_gravity;
    logic        [30:0] cur_max_rise;
    logic        [23:0] height_mem[COLUMNS];
    logic signed [31:0] velocity_mem[COLUMNS];

    logic item_taken = 1'b0;
    logic bar_taken  = 1'b0;
    int   send_wait  = 0;
    int   recv_wait  = 0;
    int   calm_left  = 0;
    int   cycle_count = 0;
    int   mismatch_count = 0;

    spectrum_bar_gravity_update_unit #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .column(column),
        .rise_rate(rise_rate),
        .frame_time(frame_time),
        .bar_valid(bar_valid),
        .bar_stall(bar_stall),
        .bar_column(bar_column),
        .bar_height(bar_height)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Wait before the next item or after a result; calm stretches have no idling at all.
    function int draw_delay();
        if (calm_left > 0)
        begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm_left = int'($urandom_range(10, 40));
        return ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 11)) : 0;
    endfunction

    // Height and velocity update of one column, floored Q16.16 products.
    function automatic bar_result_t advance_bar(input logic [4:0] col, input logic [31:0] rise,
                                                input logic [15:0] ft);
        longint      rise_q;
        longint      ft_q;
        longint      grav_q;
        longint      vel_q;
        longint      ht_q;
        bar_result_t res;
        rise_q = longint'($signed(rise));
        ft_q   = longint'(ft);
        grav_q = longint'(cur_gravity);
        if (rise_q < 0)
            rise_q = 0;
        if (rise_q > longint'(cur_max_rise))
            rise_q = longint'(cur_max_rise);
        vel_q = longint'(velocity_mem[col]);
        ht_q  = longint'(height_mem[col]);
        vel_q = vel_q + ((grav_q * ft_q) >>> 16);
        if (vel_q > 64'sd2147483647)
            vel_q = 64'sd2147483647;
        if (vel_q < -64'sd2147483648)
            vel_q = -64'sd2147483648;
        if (ht_q <= 0)
            vel_q = 0;
        ht_q = ht_q + (((vel_q + rise_q) * ft_q) >>> 16);
        if (ht_q < 0)
            ht_q = 0;
        if (ht_q > longint'(ROWS) * 65536)
            ht_q = longint'(ROWS) * 65536;
        velocity_mem[col] = vel_q[31:0];
        height_mem[col]   = ht_q[23:0];
        res.column = col;
        res.height = ht_q[20:16];
        return res;
    endfunction

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    endtask

    // Sender and receiver idling, inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                if (send_wait > 0)
                begin
                    item_valid <= 1'b0;
                    send_wait = send_wait - 1;
                end
                else if (column_updates.size() > 0)
                begin
                    next_update = column_updates.pop_front();
                    column     <= next_update.column;
                    rise_rate  <= next_update.rise_rate;
                    frame_time <= next_update.frame_time;
                    item_valid <= 1'b1;
                    send_wait = draw_delay();
                end
                else
                    item_valid <= 1'b0;
            end
            if (bar_taken)
                recv_wait = draw_delay();
            if (recv_wait > 0)
            begin
                bar_stall <= 1'b1;
                recv_wait = recv_wait - 1;
            end
            else
                bar_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("spectrum_bar_gravity_update_unit_tb: done, errors");
            $finish;
        end
        else
        begin
            item_taken <= rst_n && item_valid && !item_stall;
            bar_taken  <= rst_n && bar_valid && !bar_stall;
            if (rst_n && item_valid && !item_stall)
                pending_bars.push_back(advance_bar(column, rise_rate, frame_time));
            if (rst_n && bar_valid && !bar_stall)
            begin
                if (pending_bars.size() == 0)
                    note_mismatch("unexpected bar, column", -1, int'(bar_column));
                else
                begin
                    want_bar = pending_bars.pop_front();
                    if (bar_column !== want_bar.column)
                        note_mismatch("bar_column", int'(want_bar.column), int'(bar_column));
                    if (bar_height !== want_bar.height)
                        note_mismatch("bar_height", int'(want_bar.height), int'(bar_height));
                end
            end
        end
    end

    task automatic queue_update(input logic [4:0] col, input logic [31:0] rise,
                                input logic [15:0] ft);
        bar_update_t u;
        u.column     = col;
        u.rise_rate  = rise;
        u.frame_time = ft;
        column_updates.push_back(u);
    endtask

    function automatic logic [31:0] random_rise();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return -$urandom_range(0, 1 << 20);
            2, 3: return $urandom_range(0, 200 << 16);
            4:
            begin
                case ($urandom_range(0, 2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return 32'h0;
                endcase
            end
            default: return $urandom_range(0, 30 << 16);
        endcase
    endfunction

    function automatic logic [15:0] random_frame_time();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1, 2: return 16'($urandom_range(0, 4000));
            default:
            begin
                case ($urandom_range(0, 2))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
        endcase
    endfunction

    function automatic logic [4:0] random_column();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 3));
        return 5'($urandom_range(0, COLUMNS - 1));
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_update(random_column(), random_rise(), random_frame_time());
    endtask

    // One column driven hard at full rise and full frame time until its velocity
    // saturates, with unrelated columns mixed in.
    task automatic queue_saturation(input int hits);
        logic [4:0] hot;
        logic [4:0] other;
        int         done;
        hot  = 5'($urandom_range(0, COLUMNS - 1));
        done = 0;
        while (done < hits)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                other = random_column();
                if (other == hot)
                    other = other ^ 5'd1;
                queue_update(other, random_rise(), random_frame_time());
            end
            else
            begin
                queue_update(hot, 32'h7FFF_FFFF, 16'hFFFF);
                done = done + 1;
            end
        end
    endtask

    task automatic write_reg(input logic [sbgu_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int grav, input logic [30:0] rise_cap);
        write_reg(GRAVITY_ADDR, grav);
        cur_gravity = grav[24:0];
        write_reg(MAX_RISE_ADDR, {1'b0, rise_cap});
        cur_max_rise = rise_cap;
    endtask

    task automatic wait_for_quiet();
        while (column_updates.size() != 0 || item_valid || pending_bars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int grav;
        cur_gravity  = sbgu_pkg::GRAVITY_RESET;
        cur_max_rise = sbgu_pkg::MAX_RISE_RESET;
        for (int i = 0; i < COLUMNS; i++)
        begin
            height_mem[i]   = '0;
            velocity_mem[i] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_update(5'd0, 32'h0000_0000, 16'h0000);
        queue_update(5'd0, 32'h7FFF_FFFF, 16'hFFFF);
        queue_update(5'd0, 32'h0000_0000, 16'hFFFF);
        queue_update(5'd0, 32'h0000_0000, 16'hFFFF);
        queue_update(5'd31, 32'h8000_0000, 16'hFFFF);
        queue_update(5'd31, 32'hFFFF_FFFF, 16'h0001);
        queue_update(5'd1, 32'd10 << 16, 16'h8000);
        queue_update(5'd1, 32'h0000_0000, 16'h0001);
        queue_update(5'd1, 32'h0000_0000, 16'd6553);
        queue_update(5'd21, 32'h5555_5555, 16'hAAAA);
        queue_update(5'd10, 32'h2AAA_AAAA, 16'h5555);
        queue_update(5'd10, 32'hAAAA_AAAA, 16'h5555);
        queue_update(5'd2, 32'd327680000, 16'd3000);
        queue_update(5'd2, 32'd327680001, 16'd3000);
        queue_update(5'd3, 32'd5 << 16, 16'd1966);
        queue_update(5'd3, 32'd5 << 16, 16'd1966);
        queue_update(5'd3, 32'd0, 16'd1966);
        queue_update(5'd3, 32'd0, 16'd1966);
        wait_for_quiet();

        queue_random(150);
        wait_for_quiet();

        set_config(-16777216, 31'h7FFF_FFFF);
        queue_saturation(140);
        wait_for_quiet();

        set_config(0, 31'd0);
        queue_random(60);
        wait_for_quiet();

        set_config(16777215, 31'h7FFF_FFFF);
        queue_saturation(140);
        wait_for_quiet();

        for (int phase = 0; phase < 3; phase++)
        begin
            grav = int'($urandom_range(0, 16777216));
            if ($urandom_range(0, 3) == 0)
                set_config(-grav, 31'($urandom));
            else
                set_config(-grav, 31'($urandom_range(0, 300 << 16)));
            queue_random(50);
            wait_for_quiet();
        end

        if (pending_bars.size() != 0)
            mismatch_count = mismatch_count + 1;
        if (mismatch_count == 0)
            $display("spectrum_bar_gravity_update_unit_tb: done, clean");
        else
            $display("spectrum_bar_gravity_update_unit_tb: done, errors");
        $finish;
    end

endmodule
